// ===== rtl/core/jpeg_marker_carver_top_macros.svh =====
// Assertion macros for the JPEG marker carver.
// Used by the top level; relies on clk and rst_n being in scope.
`ifndef JPEG_MARKER_CARVER_TOP_MACROS_SVH
`define JPEG_MARKER_CARVER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset
`define JMC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jpeg_marker_carver: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define JMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jpeg_marker_carver: next-cycle check failed");

`endif

// ===== rtl/core/jmc_pkg.sv =====
// Shared constants and types for the JPEG marker carver.
// No dependencies; imported by jmc_out_buf and jpeg_marker_carver_top.
package jmc_pkg;

  localparam int COUNT_W = 14;
  localparam int MAX_RES = 3;

  localparam logic [7:0] MARK_FF  = 8'hFF;
  localparam logic [7:0] MARK_SOI = 8'hD8;
  localparam logic [7:0] MARK_EOI = 8'hD9;

  localparam logic [COUNT_W-1:0] MAX_IMAGES_RESET = COUNT_W'(9999);

  // Up to three results produced by one input byte
  typedef struct packed {
    logic [1:0]               cnt;
    logic [MAX_RES-1:0][7:0]  bytes;
    logic [MAX_RES-1:0]       first;
    logic [MAX_RES-1:0]       last;
    logic [COUNT_W-1:0]       number;
    logic                     trunc;
  } grp_t;

endpackage

// ===== rtl/core/jmc_out_buf.sv =====
// Result group register of the JPEG marker carver: holds the results of one
// byte and hands them out one per cycle while out_tready is high. Depends on jmc_pkg.
module jmc_out_buf
  import jmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  grp_t        grp,
  output logic        free,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // out_byte[7:0], image_number[21:8], zero fill
  output logic [2:0]  out_tuser,   // image_first[0], image_last[1], image_truncated[2]
  output logic        out_tlast    // run_last
);

  grp_t       grp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] ptr_r, ptr_nxt;
  logic       sel_last;
  logic       take;

  // Select the current result of the group
  assign out_tvalid = (cnt_r != 2'd0);
  assign sel_last   = (ptr_r == (cnt_r - 2'd1));
  assign take       = out_tvalid && out_tready;
  assign free       = !out_tvalid || (take && sel_last);

  assign out_tdata = {2'b00, grp_r.number, grp_r.bytes[ptr_r]};
  assign out_tuser = {grp_r.trunc && sel_last, grp_r.last[ptr_r], grp_r.first[ptr_r]};
  assign out_tlast = sel_last;

  // Advance through the group, or load the next one
  always_comb begin
    cnt_nxt = cnt_r;
    ptr_nxt = ptr_r;
    if (load) begin
      cnt_nxt = grp.cnt;
      ptr_nxt = 2'd0;
    end else if (take) begin
      if (sel_last) begin
        cnt_nxt = 2'd0;
      end else begin
        ptr_nxt = ptr_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      ptr_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      ptr_r <= ptr_nxt;
    end
  end

  // Payload: no reset
  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= grp;
    end
  end

endmodule

// ===== rtl/core/jpeg_marker_carver_top.sv =====
// Top level of the JPEG marker carver: input register, marker matcher and
// image counter. Depends on jmc_pkg, jmc_out_buf and the assertion macros.
//
// The block scans a byte stream for FF D8 FF and passes on every byte of each
// image up to and including FF D9, tagging each byte with its image ordinal.
// A byte is accepted every cycle as long as it yields at most one result and
// out_tready is high; the start marker (three results) and the end marker (two)
// hold the single output port while their results go out in turn, so
// throughput is one result per cycle while out_tready is high, set by that port.
// An input request passes the input register, then the result group register.
// The user is to write max_images through the cfg channel while the block is
// idle; the block does not enforce this. There is no clearing pass after reset.
`include "jpeg_marker_carver_top_macros.svh"

module jpeg_marker_carver_top
  import jmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data,   // max_images
  // byte stream in
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // data_byte[7:0]
  input  logic               in_tlast,   // stream_end
  // carved bytes out
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [23:0]        out_tdata,  // out_byte[7:0], image_number[21:8], zero fill
  output logic [2:0]         out_tuser,  // image_first[0], image_last[1], image_truncated[2]
  output logic               out_tlast   // run_last
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SAW_FF,
    PH_SAW_FFD8,
    PH_INSIDE,
    PH_INSIDE_FF
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               limit_r, limit_nxt;
  logic [COUNT_W-1:0] max_r;
  logic               in_valid_r;
  logic [7:0]         in_byte_r;
  logic               in_end_r;
  logic               load;
  logic               buf_free;
  grp_t               grp;

  assign cfg_ready = 1'b1;
  assign load      = in_valid_r && buf_free;
  assign in_tready = !in_valid_r || load;

  // Match markers for the held byte and build its result group
  always_comb begin
    logic [1:0] n;
    logic       lim;
    n         = 2'd0;
    lim       = limit_r || ((phase_r < PH_INSIDE) && (count_r > max_r));
    phase_nxt = phase_r;
    count_nxt = count_r;
    grp       = '0;
    grp.number = count_r;

    if (!lim) begin
      case (phase_r)
        PH_SAW_FF: begin
          if (in_byte_r == MARK_SOI) begin
            phase_nxt = PH_SAW_FFD8;
          end else if (in_byte_r == MARK_FF) begin
            phase_nxt = PH_SAW_FF;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_SAW_FFD8: begin
          if (in_byte_r == MARK_FF) begin
            grp.bytes[0] = MARK_FF;
            grp.bytes[1] = MARK_SOI;
            grp.bytes[2] = MARK_FF;
            grp.first[0] = 1'b1;
            n            = 2'd3;
            phase_nxt    = PH_INSIDE;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_INSIDE: begin
          if (in_byte_r == MARK_FF) begin
            phase_nxt = PH_INSIDE_FF;
          end else begin
            grp.bytes[0] = in_byte_r;
            n            = 2'd1;
          end
        end
        PH_INSIDE_FF: begin
          grp.bytes[0] = MARK_FF;
          if (in_byte_r == MARK_EOI) begin
            grp.bytes[1] = MARK_EOI;
            grp.last[1]  = 1'b1;
            n            = 2'd2;
            phase_nxt    = PH_IDLE;
            if (count_r >= max_r) begin
              lim = 1'b1;
            end else begin
              count_nxt = count_r + COUNT_W'(1);
            end
          end else if (in_byte_r == MARK_FF) begin
            n = 2'd1;
          end else begin
            grp.bytes[1] = in_byte_r;
            n            = 2'd2;
            phase_nxt    = PH_INSIDE;
          end
        end
        default: begin
          phase_nxt = (in_byte_r == MARK_FF) ? PH_SAW_FF : PH_IDLE;
        end
      endcase
    end

    // Flush a held FF, mark an open image cut off and restart the matcher at stream end
    if (in_end_r) begin
      if (!lim && (phase_nxt == PH_INSIDE_FF)) begin
        grp.bytes[n] = MARK_FF;
        n            = n + 2'd1;
      end
      grp.trunc = !lim && (phase_nxt >= PH_INSIDE) && (n != 2'd0);
      phase_nxt = PH_IDLE;
      count_nxt = COUNT_W'(1);
      lim       = 1'b0;
    end

    grp.cnt   = n;
    limit_nxt = lim;
  end

  // Hold the input request, matcher state and configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      phase_r    <= PH_IDLE;
      count_r    <= COUNT_W'(1);
      limit_r    <= 1'b0;
      max_r      <= MAX_IMAGES_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_r <= cfg_data;
      end
      if (load) begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
        limit_r <= limit_nxt;
      end
      if (in_tvalid && in_tready) begin
        in_valid_r <= 1'b1;
        in_byte_r  <= in_tdata;
        in_end_r   <= in_tlast;
      end else if (load) begin
        in_valid_r <= 1'b0;
      end
    end
  end

  jmc_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .grp        (grp),
    .free       (buf_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Checks on the carver's own logic
  `JMC_ASSERT_NOW(a_first_is_ff, out_tvalid && out_tuser[0], out_tdata[7:0] == MARK_FF)
  `JMC_ASSERT_NOW(a_last_is_eoi, out_tvalid && out_tuser[1], (out_tdata[7:0] == MARK_EOI) && out_tlast)
  `JMC_ASSERT_NOW(a_trunc_ends_run, out_tvalid && out_tuser[2], out_tlast && !out_tuser[1])
  `JMC_ASSERT_NEXT(a_request_held, in_tvalid && in_tready, in_valid_r)

endmodule

// ===== dv/tb_jpeg_marker_carver_top.sv =====
// Self-checking testbench for jpeg_marker_carver_top: byte streams in, carved bytes out,
// each result checked against an in-bench marker-matching predictor.
// Depends on jmc_pkg and the RTL of jpeg_marker_carver_top only.
module tb_jpeg_marker_carver_top
  import jmc_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 6;
  localparam int MAX_REPORTS    = 10;

  // Matcher phase of the predictor
  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_FF, SCAN_FF_D8, IN_IMAGE, IN_IMAGE_FF
  } carve_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } stream_item_t;

  typedef struct packed {
    logic [7:0]         data;
    logic [COUNT_W-1:0] number;
    logic               first;
    logic               last;
    logic               trunc;
    logic               run_end;
  } carved_rec_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data = '0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata = '0;
  logic               in_tlast = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [23:0]        out_tdata;
  logic [2:0]         out_tuser;
  logic               out_tlast;

  jpeg_marker_carver_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Stimulus and expectation stores
  stream_item_t       send_q [$];
  carved_rec_t        carved_q [$];
  logic [COUNT_W-1:0] cfg_q [$];
  int                 queued_items = 0;
  bit                 steady = 1'b0;

  // Predictor state
  carve_phase_t       scan_ph = SCAN_IDLE;
  logic [COUNT_W-1:0] img_count = COUNT_W'(1);
  logic               limit_hit = 1'b0;
  logic [COUNT_W-1:0] max_imgs = MAX_IMAGES_RESET;

  // Run statistics
  int err_count = 0;
  int bytes_in = 0;
  int results_seen = 0;
  int images_closed = 0;
  int images_cut = 0;
  int cfg_writes = 0;

  function automatic carved_rec_t carved_rec(input logic [7:0] b, input logic first,
                                             input logic last);
    carved_rec_t r;
    r.data    = b;
    r.number  = img_count;
    r.first   = first;
    r.last    = last;
    r.trunc   = 1'b0;
    r.run_end = 1'b0;
    return r;
  endfunction

  // Advance the matcher by one byte and queue the bytes it carves
  task automatic carve_byte(input logic [7:0] b, input logic fin);
    carved_rec_t res [3];
    int n;
    n = 0;
    if (scan_ph < IN_IMAGE && img_count > max_imgs) limit_hit = 1'b1;
    if (!limit_hit) begin
      case (scan_ph)
        SCAN_FF: begin
          if (b == MARK_SOI) scan_ph = SCAN_FF_D8;
          else if (b == MARK_FF) scan_ph = SCAN_FF;
          else scan_ph = SCAN_IDLE;
        end
        SCAN_FF_D8: begin
          if (b == MARK_FF) begin
            res[0] = carved_rec(MARK_FF, 1'b1, 1'b0);
            res[1] = carved_rec(MARK_SOI, 1'b0, 1'b0);
            res[2] = carved_rec(MARK_FF, 1'b0, 1'b0);
            n = 3;
            scan_ph = IN_IMAGE;
          end else begin
            scan_ph = SCAN_IDLE;
          end
        end
        IN_IMAGE: begin
          if (b == MARK_FF) begin
            scan_ph = IN_IMAGE_FF;
          end else begin
            res[n] = carved_rec(b, 1'b0, 1'b0);
            n++;
          end
        end
        IN_IMAGE_FF: begin
          res[n] = carved_rec(MARK_FF, 1'b0, 1'b0);
          n++;
          if (b == MARK_EOI) begin
            res[n] = carved_rec(MARK_EOI, 1'b0, 1'b1);
            n++;
            scan_ph = SCAN_IDLE;
            if (img_count >= max_imgs) limit_hit = 1'b1;
            else img_count = img_count + COUNT_W'(1);
          end else if (b != MARK_FF) begin
            res[n] = carved_rec(b, 1'b0, 1'b0);
            n++;
            scan_ph = IN_IMAGE;
          end
        end
        default: begin
          scan_ph = (b == MARK_FF) ? SCAN_FF : SCAN_IDLE;
        end
      endcase
    end
    // Stream end: flush a held FF, mark an open image cut off, start over
    if (fin) begin
      if (!limit_hit && scan_ph == IN_IMAGE_FF) begin
        res[n] = carved_rec(MARK_FF, 1'b0, 1'b0);
        n++;
      end
      if (!limit_hit && scan_ph >= IN_IMAGE && n > 0) res[n-1].trunc = 1'b1;
      scan_ph   = SCAN_IDLE;
      img_count = COUNT_W'(1);
      limit_hit = 1'b0;
    end
    if (n > 0) res[n-1].run_end = 1'b1;
    for (int i = 0; i < n; i++) carved_q.push_back(res[i]);
  endtask

  // Drive the configuration channel from its request queue
  always @(posedge clk) begin : cfg_drive
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      max_imgs = cfg_data;
      cfg_writes++;
      cfg_valid <= 1'b0;
    end else if (!cfg_valid && cfg_q.size() > 0) begin
      cfg_data  <= cfg_q.pop_front();
      cfg_valid <= 1'b1;
    end
  end

  // Drive input bytes in bursts with random gaps
  int burst_left = 0;
  int gap_left   = 0;
  always @(posedge clk) begin : byte_drive
    stream_item_t it;
    logic         nv;
    nv = in_tvalid;
    if (!rst_n) begin
      nv = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        carve_byte(in_tdata, in_tlast);
        bytes_in++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0 && !steady) begin
          gap_left--;
        end else if (send_q.size() > 0) begin
          it = send_q.pop_front();
          in_tdata <= it.data;
          in_tlast <= it.fin;
          nv = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = $urandom_range(1, 7);
          end
        end
      end
    end
    in_tvalid <= nv;
  end

  // Stall the result side on its own run/stall pattern
  int run_left   = 0;
  int stall_left = 0;
  always @(posedge clk) begin : out_stall
    logic r;
    if (steady) begin
      r = 1'b1;
    end else if (stall_left > 0) begin
      r = 1'b0;
      stall_left--;
    end else if (run_left > 0) begin
      r = 1'b1;
      run_left--;
    end else begin
      r = 1'b1;
      run_left   = $urandom_range(0, 12);
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
                                               : $urandom_range(1, 4);
    end
    out_tready <= r;
  end

  // Compare each carved byte with the oldest expectation
  always @(posedge clk) begin : out_check
    carved_rec_t exp_rec;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tuser[1]) images_closed++;
      if (out_tuser[2]) images_cut++;
      if (carved_q.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("unexpected result: tdata=%h tuser=%b tlast=%b",
                   out_tdata, out_tuser, out_tlast);
      end else begin
        exp_rec = carved_q.pop_front();
        if (out_tdata[7:0] !== exp_rec.data || out_tdata[21:8] !== exp_rec.number ||
            out_tdata[23:22] !== 2'b00 || out_tuser[0] !== exp_rec.first ||
            out_tuser[1] !== exp_rec.last || out_tuser[2] !== exp_rec.trunc ||
            out_tlast !== exp_rec.run_end) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("mismatch: exp byte=%h num=%0d f/l/t=%b%b%b run_last=%b",
                     exp_rec.data, exp_rec.number, exp_rec.first, exp_rec.last,
                     exp_rec.trunc, exp_rec.run_end);
            $display("          got byte=%h num=%0d f/l/t=%b%b%b run_last=%b fill=%b",
                     out_tdata[7:0], out_tdata[21:8], out_tuser[0], out_tuser[1],
                     out_tuser[2], out_tlast, out_tdata[23:22]);
          end
        end
      end
    end
  end

  // Abort when nothing moves for too long
  int idle_cycles = 0;
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_jpeg_marker_carver_top: errors");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic fin);
    stream_item_t it;
    it.data = b;
    it.fin  = fin;
    send_q.push_back(it);
    queued_items++;
  endtask

  // Bias towards the marker bytes so partial matches happen often
  function automatic logic [7:0] noise_byte();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 25) return MARK_FF;
    if (sel < 35) return MARK_SOI;
    if (sel < 45) return MARK_EOI;
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly well-formed images with random bodies, plus broken starts and noise
  task automatic queue_random(input int n_items, input bit keep_open);
    int start;
    int len;
    int k;
    int sel;
    start = queued_items;
    while (queued_items - start < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        len = $urandom_range(0, 2);
        for (k = 0; k < len; k++) push_byte(noise_byte(), 1'b0);
        push_byte(MARK_FF, 1'b0);
        push_byte(MARK_SOI, 1'b0);
        push_byte(MARK_FF, 1'b0);
        len = $urandom_range(0, 10);
        for (k = 0; k < len; k++)
          push_byte(($urandom_range(0, 99) < 20) ? MARK_FF : 8'($urandom_range(0, 255)), 1'b0);
        if ($urandom_range(0, 99) < 80) begin
          push_byte(MARK_FF, 1'b0);
          push_byte(MARK_EOI, 1'b0);
        end
      end else if (sel < 80) begin
        push_byte(MARK_FF, 1'b0);
        if ($urandom_range(0, 1)) push_byte(MARK_SOI, 1'b0);
        push_byte(noise_byte(), 1'b0);
      end else begin
        push_byte(noise_byte(), 1'b0);
      end
      if ($urandom_range(0, 99) < 12) push_byte(noise_byte(), 1'b1);
    end
    if (!keep_open) push_byte(noise_byte(), 1'b1);
  endtask

  // Wait until every request is through and the pipeline has settled
  task automatic wait_drained();
    do @(negedge clk);
    while (send_q.size() != 0 || in_tvalid || carved_q.size() != 0 ||
           cfg_valid || cfg_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_max(input logic [COUNT_W-1:0] v);
    cfg_q.push_back(v);
    wait_drained();
  endtask

  // Basic stream: open, data extremes, held FF, double FF before close, failed starts,
  // rescan after FF FF, failure at the third byte, held FF flushed at stream end
  localparam logic [7:0] BASIC_SEQ [24] = '{
    MARK_FF, MARK_SOI, MARK_FF, 8'h00, MARK_FF, 8'h80, MARK_FF, MARK_FF, MARK_EOI,
    MARK_FF, 8'h12, MARK_FF, MARK_FF, MARK_SOI, MARK_FF, MARK_FF, MARK_EOI,
    MARK_FF, MARK_SOI, 8'h00, MARK_FF, MARK_SOI, MARK_FF, MARK_FF
  };
  // Limit of one image: the second start is ignored until the stream ends
  localparam logic [7:0] LIMIT_SEQ [9] = '{
    MARK_FF, MARK_SOI, MARK_FF, MARK_FF, MARK_EOI, MARK_FF, MARK_SOI, MARK_FF, 8'h11
  };

  initial begin : main
    logic [COUNT_W-1:0] plan [7];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 24; i++) push_byte(BASIC_SEQ[i], i == 23);
    wait_drained();

    write_max(COUNT_W'(1));
    for (int i = 0; i < 9; i++) push_byte(LIMIT_SEQ[i], i == 8);
    wait_drained();

    // Third phase leaves its stream open so the next limit lands below the count
    plan[0] = COUNT_W'(2);
    plan[1] = COUNT_W'(9999);
    plan[2] = COUNT_W'(3);
    plan[3] = COUNT_W'(1);
    plan[4] = COUNT_W'($urandom_range(1, 6));
    plan[5] = COUNT_W'($urandom_range(1, 9999));
    plan[6] = COUNT_W'(9999);
    for (int p = 0; p < 7; p++) begin
      write_max(plan[p]);
      steady = (p == 1);
      queue_random(42, p == 2);
      wait_drained();
    end

    if (carved_q.size() != 0) begin
      err_count += carved_q.size();
      $display("%0d expected results never arrived", carved_q.size());
    end
    $display("run covered %0d input bytes and %0d carved bytes across %0d limit settings",
             bytes_in, results_seen, cfg_writes);
    $display("images closed: %0d, images cut off at stream end: %0d, failures: %0d",
             images_closed, images_cut, err_count);
    if (err_count == 0) begin
      $display("tb_jpeg_marker_carver_top: clean");
    end else begin
      $display("tb_jpeg_marker_carver_top: errors");
    end
    $finish;
  end

endmodule
